### hdl/bormom_pkg.sv
// Shared constants, codes and control types of the binary overlap radial moment block.
package bormom_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int PIX_BITS   = 8;
    localparam int ROOT_BITS  = 28;
    localparam int COUNT_BITS = 21;
    localparam int CFG_BITS   = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_BITS-1:0] RST_IMAGE_HEIGHT = 11'd480;

    localparam logic [PIX_BITS-1:0] PIX_FULL = 8'hFF;

    // Operand pair of the serial multiply-accumulate.
    typedef enum logic [1:0] {
        PH_SUMSQ = 2'd0,
        PH_COL   = 2'd1,
        PH_ROW   = 2'd2
    } mul_phase_t;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       mul_load;
        logic       mul_step;
        mul_phase_t phase;
        logic       div_load;
        logic       div_step;
        logic       sqrt_step;
        logic       put;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic count_zero;
        logic mul_zero;
    } sts_t;

endpackage

### hdl/bormom_if.sv
// Handshake interfaces: pixel pair items, result items and configuration writes.
interface bormom_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bormom_pkg::PIX_BITS-1:0] pixel_a;
    logic [bormom_pkg::PIX_BITS-1:0] pixel_b;
    modport source (output valid, output pixel_a, output pixel_b, input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, output ready);
endinterface

interface bormom_res_if;
    logic                              valid;
    logic                              ready;
    logic [bormom_pkg::ROOT_BITS-1:0]  root_moment;
    logic [bormom_pkg::COUNT_BITS-1:0] hit_count;
    logic                              empty_overlap;
    modport source (output valid, output root_moment, output hit_count,
                    output empty_overlap, input ready);
    modport sink   (input valid, input root_moment, input hit_count,
                    input empty_overlap, output ready);
endinterface

interface bormom_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bormom_pkg::CFG_IDX_W-1:0] index;
    logic [bormom_pkg::CFG_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bormom_datapath.sv
// Datapath: accumulators, serial multiplier, restoring divider and square root.
module bormom_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 8,
    parameter int SW         = 80
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bormom_pkg::PIX_BITS-1:0]   pixel_a,
    input  logic [bormom_pkg::PIX_BITS-1:0]   pixel_b,
    input  logic                              cfg_we,
    input  logic [bormom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bormom_pkg::CFG_BITS-1:0]   cfg_data,
    input  bormom_pkg::cmd_t                  cmd,
    output bormom_pkg::sts_t                  sts,
    output logic [bormom_pkg::ROOT_BITS-1:0]  root_moment,
    output logic [bormom_pkg::COUNT_BITS-1:0] hit_count,
    output logic                              empty_overlap
);
    import bormom_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SXW  = CW + NW;
    localparam int SYW  = RW + NW;
    localparam int PW   = 2 * ((CW > RW) ? CW : RW) + 1;
    localparam int SQW  = PW + NW;
    localparam int NUMW = NW + SQW;
    localparam int MPW  = (SXW > SYW) ? ((SXW > NW) ? SXW : NW) : ((SYW > NW) ? SYW : NW);
    localparam int DWW  = $clog2(MAX_WIDTH + 1);
    localparam int DWH  = $clog2(MAX_HEIGHT + 1);
    localparam int EW   = ((DWW > DWH) ? ((DWW > CFG_BITS) ? DWW : CFG_BITS)
                                       : ((DWH > CFG_BITS) ? DWH : CFG_BITS)) + 1;
    localparam int HW   = SW / 2;
    localparam int XW   = HW + ROOT_BITS;

    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [NW-1:0]       count_reg;
    logic [SXW-1:0]      sum_col_reg;
    logic [SYW-1:0]      sum_row_reg;
    logic [SQW-1:0]      sum_sq_reg;
    logic [NUMW-1:0]     acc_reg, mcand_reg;
    logic [MPW-1:0]      mplier_reg;
    logic [SW-1:0]       qr_reg;
    logic [NW-1:0]       drem_reg;
    logic [HW:0]         srem_reg;
    logic [HW-1:0]       root_reg;
    logic [ROOT_BITS-1:0] root_out_reg;
    logic [COUNT_BITS-1:0] hit_out_reg;
    logic                empty_out_reg;

    logic [EW-1:0] w_ext, h_ext, w_cl, h_cl;
    logic          last_col, last_row, match;
    logic [PW-1:0] sq_term;
    logic [NW:0]   drem_sh, drem_sub;
    logic          qbit;
    logic [HW+2:0] srem_sh, srem_sub, trial;
    logic          rbit;
    logic [XW-1:0] root_x;

    // Clamp the frame size: zero reads as one, oversize saturates.
    always_comb
    begin
        w_ext = EW'(width_reg);
        h_ext = EW'(height_reg);
        if (w_ext == '0)
            w_cl = EW'(1);
        else if (w_ext > EW'(MAX_WIDTH))
            w_cl = EW'(MAX_WIDTH);
        else
            w_cl = w_ext;
        if (h_ext == '0)
            h_cl = EW'(1);
        else if (h_ext > EW'(MAX_HEIGHT))
            h_cl = EW'(MAX_HEIGHT);
        else
            h_cl = h_ext;
        last_col = (EW'(col_reg) + EW'(1)) >= w_cl;
        last_row = (EW'(row_reg) + EW'(1)) >= h_cl;
        match    = (pixel_a & pixel_b) == PIX_FULL;
        sq_term  = PW'(col_reg) * PW'(col_reg) + PW'(row_reg) * PW'(row_reg);
        col_next = last_col ? '0 : col_reg + CW'(1);
        row_next = last_col ? (last_row ? '0 : row_reg + RW'(1)) : row_reg;
    end

    always_comb
    begin
        drem_sh  = {drem_reg, qr_reg[SW-1]};
        qbit     = drem_sh >= {1'b0, count_reg};
        drem_sub = drem_sh - {1'b0, count_reg};
        srem_sh  = {srem_reg, qr_reg[SW-1:SW-2]};
        trial    = {1'b0, root_reg, 2'b01};
        rbit     = srem_sh >= trial;
        srem_sub = srem_sh - trial;
        root_x   = XW'(root_reg);
    end

    assign sts.frame_end  = last_col && last_row;
    assign sts.count_zero = (count_reg == '0);
    assign sts.mul_zero   = (mplier_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            col_reg     <= '0;
            row_reg     <= '0;
            count_reg   <= '0;
            sum_col_reg <= '0;
            sum_row_reg <= '0;
            sum_sq_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear)
            begin
                count_reg   <= '0;
                sum_col_reg <= '0;
                sum_row_reg <= '0;
                sum_sq_reg  <= '0;
            end
            else if (cmd.accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (match)
                begin
                    count_reg   <= count_reg + NW'(1);
                    sum_col_reg <= sum_col_reg + SXW'(col_reg);
                    sum_row_reg <= sum_row_reg + SYW'(row_reg);
                    sum_sq_reg  <= sum_sq_reg + SQW'(sq_term);
                end
            end
        end
    end

    // Serial engines; payload only, sequenced by the controller.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            case (cmd.phase)
                PH_SUMSQ:
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= NUMW'(sum_sq_reg);
                    mplier_reg <= MPW'(count_reg);
                end
                PH_COL:
                begin
                    mcand_reg  <= NUMW'(sum_col_reg);
                    mplier_reg <= MPW'(sum_col_reg);
                end
                PH_ROW:
                begin
                    mcand_reg  <= NUMW'(sum_row_reg);
                    mplier_reg <= MPW'(sum_row_reg);
                end
                default:
                begin
                    mcand_reg  <= '0;
                    mplier_reg <= '0;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
                acc_reg <= (cmd.phase == PH_SUMSQ) ? acc_reg + mcand_reg
                                                    : acc_reg - mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end

        if (cmd.div_load)
        begin
            qr_reg   <= SW'(acc_reg) << (2 * FRAC_BITS);
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            qr_reg   <= {qr_reg[SW-2:0], qbit};
            drem_reg <= qbit ? drem_sub[NW-1:0] : drem_sh[NW-1:0];
        end
        else if (cmd.sqrt_step)
        begin
            qr_reg   <= qr_reg << 2;
            srem_reg <= rbit ? srem_sub[HW:0] : srem_sh[HW:0];
            root_reg <= {root_reg[HW-2:0], rbit};
        end

        if (cmd.put)
        begin
            empty_out_reg <= sts.count_zero;
            hit_out_reg   <= COUNT_BITS'(count_reg);
            if (sts.count_zero)
                root_out_reg <= '0;
            else if (root_x > XW'({ROOT_BITS{1'b1}}))
                root_out_reg <= '1;
            else
                root_out_reg <= root_x[ROOT_BITS-1:0];
        end
    end

    assign root_moment   = root_out_reg;
    assign hit_count     = hit_out_reg;
    assign empty_overlap = empty_out_reg;

endmodule

### hdl/bormom_ctrl.sv
// Controller: frame accumulation, per-frame finish sequence and output hand-off.
module bormom_ctrl #(
    parameter int SW = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bormom_pkg::sts_t sts,
    output bormom_pkg::cmd_t cmd
);
    import bormom_pkg::*;

    localparam int SQRT_STEPS = SW / 2;
    localparam int CNTW       = $clog2(SW + 1);

    typedef enum logic [5:0] {
        S_ACCUM = 6'b000001,
        S_LOAD  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_SQRT  = 6'b010000,
        S_PUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    mul_phase_t phase_reg, phase_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_ACCUM);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.phase      = phase_reg;
        case (state_reg)
            S_ACCUM:
            begin
                cmd.accept = in_valid;
                if (in_valid && sts.frame_end)
                begin
                    phase_next = PH_SUMSQ;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.count_zero)
                    state_next = S_PUT;
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                if (sts.mul_zero)
                begin
                    if (phase_reg == PH_ROW)
                    begin
                        cmd.div_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_SUMSQ) ? PH_COL : PH_ROW;
                        state_next = S_LOAD;
                    end
                end
                else
                    cmd.mul_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNTW'(SW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                    cnt_next = cnt_reg + CNTW'(1);
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNTW'(SQRT_STEPS - 1))
                    state_next = S_PUT;
                else
                    cnt_next = cnt_reg + CNTW'(1);
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    cmd.put        = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACCUM;
                end
            end
            default:
                state_next = S_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            phase_reg     <= PH_SUMSQ;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/binary_overlap_radial_moment.sv
// Top level of the binary overlap radial moment block.
//
//  channel  modport  moves                                       when
//  pix      sink     pixel_a, pixel_b (one raster pixel pair)    valid & ready
//  res      source   root_moment, hit_count, empty_overlap       valid & ready
//  cfg      sink     index, data (image_width, image_height)     valid & ready
//
// Pixel items are taken back to back while the frame streams in. After the last
// pixel of a frame the pixel input holds off for the finish sequence: a serial
// shift-add multiply (one multiplier bit per cycle, for the count and the column
// and row sums), then a restoring divide and a restoring square root, one
// quotient bit and one root bit per cycle. The result sits in an output
// register, so the next frame streams in while it waits. Reset clears positions,
// sums and the pending result, and restores the default frame size.
// Configuration is taken in every cycle.
module binary_overlap_radial_moment #(
    parameter int MAX_WIDTH  = bormom_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bormom_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bormom_pkg::DEF_FRAC_BITS
) (
    input logic         clk,
    input logic         rst_n,
    bormom_pix_if.sink  pix,
    bormom_res_if.source res,
    bormom_cfg_if.sink  cfg
);
    import bormom_pkg::*;

    // Widths of the finish sequence: the moment numerator, scaled by the
    // fraction bits, rounded up to an even width for the two-bit root steps.
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PW   = 2 * ((CW > RW) ? CW : RW) + 1;
    localparam int NUMW = NW + PW + NW;
    localparam int TW   = NUMW + 2 * FRAC_BITS;
    localparam int SW   = TW + (TW % 2);

    cmd_t cmd;
    sts_t sts;

    // Configuration writes never stall.
    assign cfg.ready = 1'b1;

    bormom_ctrl #(
        .SW (SW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bormom_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .SW         (SW)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_a       (pix.pixel_a),
        .pixel_b       (pix.pixel_b),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cmd           (cmd),
        .sts           (sts),
        .root_moment   (res.root_moment),
        .hit_count     (res.hit_count),
        .empty_overlap (res.empty_overlap)
    );

endmodule
